// ----- sv/slcfp_pkg.sv -----
package slcfp_pkg;

    // Field widths of the received byte, of one result beat and of the byte counter
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 7;
    localparam int BIDX_W  = 6;
    localparam int CNT_W   = 7;
    localparam int TDATA_W = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
    localparam logic [1:0] REG_TRAILER_BYTE = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE_RST = 8'h0D;

    // One result beat before packing
    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [PLEN_W-1:0] payload_len;
        logic              has_payload;
        logic [BIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } out_beat_t;

endpackage

// ----- sv/slcfp_ram.sv -----
module slcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read port that holds its data between reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/slcfp_out_stage.sv -----
module slcfp_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  slcfp_pkg::out_beat_t          beat_in,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slcfp_pkg::TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import slcfp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;

    // Slot can take a beat when empty or when its beat leaves this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the beat is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = beat_reg.last;
    assign m_tdata  = {2'b00, beat_reg.payload_byte, beat_reg.byte_index,
                       beat_reg.has_payload, beat_reg.payload_len, beat_reg.command};

endmodule

// ----- sv/sync_length_checksum_frame_parser.sv -----
// Result path: a verified frame's first beat goes through ST_ZERO and the output register
//   for a zero-length frame, and through ST_RD, ST_LD and the output register otherwise.
// Throughput: 1 byte per cycle while parsing; each payload beat is read from the payload
//   memory (ST_RD) before it is loaded (ST_LD), and input stalls while beats leave.
// Reset (aresetn low, synchronous): parser hunts for the first sync byte, output
//   empty, configuration back to its defaults; payload memory is not cleared.
module sync_length_checksum_frame_parser #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration writes
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [slcfp_pkg::BYTE_W-1:0]  cfg_wdata,
    // Received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slcfp_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] rx_byte
    // Result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] command, [14:8] payload_len, [15] has_payload,
    // [21:16] byte_index, [29:22] payload_byte, [31:30] zero
    output logic [slcfp_pkg::TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import slcfp_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [BYTE_W:0] MAX_LEN = (BYTE_W+1)'(MAX_PAYLOAD);

    localparam logic [3:0] ST_HUNT  = 4'd0;
    localparam logic [3:0] ST_SYNC2 = 4'd1;
    localparam logic [3:0] ST_CMD   = 4'd2;
    localparam logic [3:0] ST_LEN   = 4'd3;
    localparam logic [3:0] ST_DATA  = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_TRAIL = 4'd6;
    localparam logic [3:0] ST_SKIP  = 4'd7;
    localparam logic [3:0] ST_RD    = 4'd8;
    localparam logic [3:0] ST_LD    = 4'd9;
    localparam logic [3:0] ST_ZERO  = 4'd10;

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] trailer_reg;

    logic [3:0]        state_reg,  state_next;
    logic [BYTE_W-1:0] cmd_reg,    cmd_next;
    logic [BYTE_W-1:0] len_reg,    len_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [BYTE_W-1:0] sum_reg,    sum_next;
    logic [BYTE_W-1:0] eidx_reg,   eidx_next;

    logic              in_acc;
    logic [BYTE_W-1:0] rx;
    logic [CNT_W-1:0]  count_inc;
    logic              mem_we;
    logic              mem_re;
    logic [BYTE_W-1:0] mem_rdata;
    logic              out_free;
    logic              out_load;
    logic              emit_last;
    out_beat_t         beat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            trailer_reg     <= TRAILER_BYTE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:   sync_first_reg  <= cfg_wdata;
                REG_SYNC_SECOND:  sync_second_reg <= cfg_wdata;
                REG_TRAILER_BYTE: trailer_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Parse states take bytes; emit states hold the input
    assign s_tready  = !state_reg[3];
    assign in_acc    = s_tvalid && s_tready;
    assign rx        = s_tdata;
    assign count_inc = count_reg + CNT_W'(1);
    assign emit_last = (eidx_reg + BYTE_W'(1)) == len_reg;

    // Payload store: written while parsing, read while emitting, never both
    assign mem_we = in_acc && (state_reg == ST_DATA)
                    && ({{(BYTE_W+1-CNT_W){1'b0}}, count_reg} < MAX_LEN);
    assign mem_re = (state_reg == ST_RD);

    slcfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(count_reg)),
        .wdata (rx),
        .re    (mem_re),
        .raddr (AW'(eidx_reg)),
        .rdata (mem_rdata)
    );

    // Build the result beat for the current emit state
    always_comb begin
        beat.command     = cmd_reg;
        beat.payload_len = len_reg[PLEN_W-1:0];
        if (state_reg == ST_ZERO) begin
            beat.has_payload  = 1'b0;
            beat.byte_index   = '0;
            beat.payload_byte = '0;
            beat.last         = 1'b1;
        end else begin
            beat.has_payload  = 1'b1;
            beat.byte_index   = eidx_reg[BIDX_W-1:0];
            beat.payload_byte = mem_rdata;
            beat.last         = emit_last;
        end
    end

    assign out_load = out_free && ((state_reg == ST_LD) || (state_reg == ST_ZERO));

    // Parser and emit sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        eidx_next  = eidx_reg;
        unique case (state_reg)
            ST_HUNT: begin
                if (in_acc && (rx == sync_first_reg)) state_next = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (in_acc) state_next = (rx == sync_second_reg) ? ST_CMD : ST_HUNT;
            end
            ST_CMD: begin
                if (in_acc) begin
                    cmd_next   = rx;
                    sum_next   = rx;
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (in_acc) begin
                    len_next   = rx;
                    sum_next   = sum_reg + rx;
                    count_next = '0;
                    if (rx == '0) begin
                        state_next = ST_SUM;
                    end else if ({1'b0, rx} > MAX_LEN) begin
                        state_next = ST_HUNT;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (in_acc) begin
                    count_next = count_inc;
                    sum_next   = sum_reg + rx;
                    if ({{(BYTE_W-CNT_W){1'b0}}, count_inc} >= len_reg) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (in_acc) begin
                    eidx_next = '0;
                    if (rx != sum_reg) begin
                        state_next = ST_TRAIL;
                    end else if (len_reg == '0) begin
                        state_next = ST_ZERO;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_TRAIL: begin
                if (in_acc) state_next = (rx == trailer_reg) ? ST_SKIP : ST_HUNT;
            end
            ST_SKIP: begin
                if (in_acc) state_next = ST_HUNT;
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                if (out_free) begin
                    if (emit_last) begin
                        state_next = ST_TRAIL;
                    end else begin
                        eidx_next  = eidx_reg + BYTE_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_ZERO: begin
                if (out_free) state_next = ST_TRAIL;
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            eidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            eidx_reg  <= eidx_next;
        end
    end

    slcfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .beat_in  (beat),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sv/slcfp_checker.sv -----
module slcfp_checker #(
    parameter int MAX_PAYLOAD = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [slcfp_pkg::TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import slcfp_pkg::*;

    localparam logic WIDE = (MAX_PAYLOAD > 64);

    // Stalled beat stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A beat without payload is the single closing beat of an empty frame
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[15] |->
            m_tlast && (m_tdata[21:16] == 6'd0) && (m_tdata[29:22] == 8'd0)
            && (m_tdata[14:8] == 7'd0))
        else $error("empty-frame beat malformed");

    // Payload index stays inside the frame length (not checked when MAX_PAYLOAD exceeds 64)
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> WIDE || ({1'b0, m_tdata[21:16]} < m_tdata[14:8]))
        else $error("byte index beyond payload length");

endmodule

bind sync_length_checksum_frame_parser slcfp_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
) u_slcfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
